>>> src/fsd_pkg.sv
`default_nettype none

package fsd_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	localparam int PIX_W     = 8;
	localparam int WIDTH_W   = 12;
	localparam int HEIGHT_W  = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CMP_W     = (WIDTH_W > ADDR_W) ? WIDTH_W : ADDR_W + 1;

	localparam int ERR_W     = 14;
	localparam int FRAC_W    = 4;
	localparam int QUOT_W    = ERR_W - FRAC_W;
	localparam int VAL_W     = QUOT_W + 1;
	localparam int DIFF_W    = PIX_W + 1;

	localparam int PIX_MAX   = 255;
	localparam logic [PIX_W-1:0] THRESHOLD = PIX_W'(127);

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(2048);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(480);

	localparam int OUT_DEPTH = 4;
	localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	localparam int NARROW_COLS = 3;
	localparam logic [1:0] ROW_GAP = 2'd2;

	typedef logic signed [ERR_W-1:0] err_t;

	typedef struct packed {
		logic              first_col;
		logic              last_col;
		logic              last_row;
		logic              wbank;
		logic [ADDR_W-1:0] x;
	} pix_ctl_t;

	typedef struct packed {
		logic              en;
		logic              bank;
		logic [ADDR_W-1:0] addr;
		err_t              data;
	} err_wr_t;

	typedef struct packed {
		logic pixel_on;
		logic end_of_row;
		logic end_of_image;
	} result_t;

endpackage

`default_nettype wire

>>> src/floyd_steinberg_dither.sv
`default_nettype none

// Result path: input stage register and row-store read, then the output buffer.
// Throughput: one pixel per clock while the buffer has room; after a row of three
// pixels or fewer, bar the last, in_ready drops so row-store writes land before reads.
// Row corrections live in two ping-pong row stores of one read and one write port each.
// Reset: arst_n asynchronous; counters, carry and buffer clear, width 2048, height 480.
module floyd_steinberg_dither import fsd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output      logic                 in_ready,
	input  wire logic [PIX_W-1:0]     grey_level,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      logic                 pixel_on,
	output      logic                 end_of_row,
	output      logic                 end_of_image,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [WIDTH_W-1:0]  image_width_q;
	logic [HEIGHT_W-1:0] image_height_q;
	logic [ADDR_W-1:0]   col_q;
	logic [HEIGHT_W-1:0] row_q;
	logic                first_row_q;
	logic                bank_q;
	logic [1:0]          stall_q;

	logic              valid_s1;
	logic [PIX_W-1:0]  grey_s1;
	pix_ctl_t          ctl_s1;
	logic              mask_s1;
	logic              rbank_s1;
	err_t              carry_q;

	logic [CMP_W-1:0]     w_eff;
	logic                 last_col, last_row, accept;
	logic [OUT_LVL_W-1:0] fill;
	logic [ERR_W-1:0]     rdata0, rdata1;
	err_wr_t              wr;

	err_t                     rd_err, cur_err, corr, corr_adj, dext, carry_nxt;
	logic signed [QUOT_W-1:0] corr_int;
	logic signed [VAL_W-1:0]  sum;
	logic [PIX_W-1:0]         level_c;
	logic                     on;
	logic signed [DIFF_W-1:0] diff;
	result_t                  res, head;

	always_comb begin
		if (image_width_q < WIDTH_W'(2))
			w_eff = CMP_W'(2);
		else if (CMP_W'(image_width_q) > CMP_W'(MAX_WIDTH))
			w_eff = CMP_W'(MAX_WIDTH);
		else
			w_eff = CMP_W'(image_width_q);
		last_col = CMP_W'(col_q) >= w_eff - CMP_W'(1);
		last_row = (image_height_q == '0) || (row_q >= image_height_q - HEIGHT_W'(1));
	end

	assign in_ready = (stall_q == '0) && ((fill + OUT_LVL_W'(valid_s1)) < OUT_LVL_W'(OUT_DEPTH));
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= WIDTH_RESET;
			image_height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			first_row_q <= 1'b1;
			bank_q      <= 1'b0;
			stall_q     <= '0;
			valid_s1    <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept && last_col && !last_row && (CMP_W'(col_q) < CMP_W'(NARROW_COLS)))
				stall_q <= ROW_GAP;
			else if (stall_q != '0)
				stall_q <= stall_q - 2'd1;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					if (last_row) begin
						row_q       <= '0;
						first_row_q <= 1'b1;
					end else begin
						row_q       <= row_q + HEIGHT_W'(1);
						first_row_q <= 1'b0;
						bank_q      <= ~bank_q;
					end
				end else begin
					col_q <= col_q + ADDR_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			grey_s1          <= grey_level;
			ctl_s1.first_col <= (col_q == '0);
			ctl_s1.last_col  <= last_col;
			ctl_s1.last_row  <= last_row;
			ctl_s1.wbank     <= ~bank_q;
			ctl_s1.x         <= col_q;
			mask_s1          <= first_row_q;
			rbank_s1         <= bank_q;
		end
	end

	fsd_ram #(.DEPTH(MAX_WIDTH), .WIDTH(ERR_W)) u_ram0 (
		.clk   (clk),
		.we    (wr.en && !wr.bank),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (accept),
		.raddr (col_q),
		.rdata (rdata0)
	);

	fsd_ram #(.DEPTH(MAX_WIDTH), .WIDTH(ERR_W)) u_ram1 (
		.clk   (clk),
		.we    (wr.en && wr.bank),
		.waddr (wr.addr),
		.wdata (wr.data),
		.re    (accept),
		.raddr (col_q),
		.rdata (rdata1)
	);

	always_comb begin
		rd_err   = rbank_s1 ? $signed(rdata1) : $signed(rdata0);
		cur_err  = mask_s1 ? '0 : rd_err;
		corr     = cur_err + carry_q;
		corr_adj = corr[ERR_W-1] ? corr + err_t'(15) : corr;
		corr_int = QUOT_W'(corr_adj >>> FRAC_W);
		sum      = $signed({{(VAL_W-PIX_W){1'b0}}, grey_s1}) + VAL_W'(corr_int);
		if (sum < 0)
			level_c = '0;
		else if (sum > VAL_W'(PIX_MAX))
			level_c = PIX_W'(PIX_MAX);
		else
			level_c = sum[PIX_W-1:0];
		on   = level_c > THRESHOLD;
		diff = on ? $signed({1'b0, level_c}) - DIFF_W'(PIX_MAX) : $signed({1'b0, level_c});
		dext = ERR_W'(diff);

		if (ctl_s1.last_row)
			carry_nxt = ctl_s1.last_col ? '0 : dext * err_t'(16);
		else if (ctl_s1.first_col)
			carry_nxt = dext * err_t'(8);
		else if (ctl_s1.last_col)
			carry_nxt = '0;
		else
			carry_nxt = dext * err_t'(7);

		res.pixel_on     = on;
		res.end_of_row   = ctl_s1.last_col;
		res.end_of_image = ctl_s1.last_col && ctl_s1.last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			carry_q <= '0;
		else if (valid_s1)
			carry_q <= carry_nxt;
	end

	fsd_diffuse u_diffuse (
		.clk    (clk),
		.arst_n (arst_n),
		.valid  (valid_s1),
		.ctl    (ctl_s1),
		.diff   (diff),
		.wr     (wr)
	);

	fsd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (valid_s1),
		.push_data (res),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.head      (head),
		.fill      (fill)
	);

	assign pixel_on     = head.pixel_on;
	assign end_of_row   = head.end_of_row;
	assign end_of_image = head.end_of_image;

`ifndef NO_ASSERTIONS
	a_no_rw_same_entry: assert property (@(posedge clk) disable iff (!arst_n)
		accept && wr.en && (wr.bank == bank_q) |-> wr.addr != col_q)
		else $error("row store read and write hit the same entry");

	a_carry_clear_at_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && ctl_s1.first_col |-> carry_q == '0)
		else $error("right carry not clear at first column");
`endif

endmodule

`default_nettype wire

>>> src/fsd_ram.sv
`default_nettype none

module fsd_ram #(
	parameter int DEPTH = 2048,
	parameter int WIDTH = 14
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

>>> src/fsd_diffuse.sv
`default_nettype none

module fsd_diffuse import fsd_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid,
	input  wire pix_ctl_t          ctl,
	input  wire logic [DIFF_W-1:0] diff,
	output      err_wr_t           wr
);

	logic                     valid_s2;
	pix_ctl_t                 ctl_s2;
	logic signed [DIFF_W-1:0] diff_s2;
	err_t                     pa_q;
	err_t                     pb_q;
	err_wr_t                  pend_q;

	err_t    dx, d2, d3, d5, d6, d10;
	err_wr_t s2_wr;
	logic    active;

	always_comb begin
		dx  = ERR_W'(diff_s2);
		d2  = dx * err_t'(2);
		d3  = dx * err_t'(3);
		d5  = dx * err_t'(5);
		d6  = dx * err_t'(6);
		d10 = dx * err_t'(10);

		active = valid_s2 && !ctl_s2.last_row;

		s2_wr.en   = active && !ctl_s2.first_col;
		s2_wr.bank = ctl_s2.wbank;
		s2_wr.addr = ctl_s2.x - ADDR_W'(1);
		s2_wr.data = pa_q + (ctl_s2.last_col ? d6 : d3);

		wr = pend_q.en ? pend_q : s2_wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			pend_q   <= '0;
		end else begin
			valid_s2    <= valid;
			pend_q.en   <= active && ctl_s2.last_col;
			pend_q.bank <= ctl_s2.wbank;
			pend_q.addr <= ctl_s2.x;
			pend_q.data <= pb_q + d10;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s2  <= ctl;
		diff_s2 <= $signed(diff);
		if (active) begin
			if (ctl_s2.first_col) begin
				pa_q <= d6;
				pb_q <= d2;
			end else if (!ctl_s2.last_col) begin
				pa_q <= pb_q + d5;
				pb_q <= dx;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_port_clash: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q.en |-> !s2_wr.en)
		else $error("row store write port claimed twice");
`endif

endmodule

`default_nettype wire

>>> src/fsd_out_buf.sv
`default_nettype none

module fsd_out_buf import fsd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire result_t              push_data,
	output      logic                 out_valid,
	input  wire logic                 out_ready,
	output      result_t              head,
	output      logic [OUT_LVL_W-1:0] fill
);

	result_t              buf_q [OUT_DEPTH];
	logic [OUT_PTR_W-1:0] wr_ptr_q;
	logic [OUT_PTR_W-1:0] rd_ptr_q;
	logic [OUT_LVL_W-1:0] fill_q;
	logic                 pop;

	assign out_valid = (fill_q != '0);
	assign head      = buf_q[rd_ptr_q];
	assign fill      = fill_q;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + OUT_PTR_W'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + OUT_PTR_W'(1);
			if (push && !pop)
				fill_q <= fill_q + OUT_LVL_W'(1);
			else if (pop && !push)
				fill_q <= fill_q - OUT_LVL_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wr_ptr_q] <= push_data;
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> fill_q != OUT_LVL_W'(OUT_DEPTH))
		else $error("result buffer overflow");
`endif

endmodule

`default_nettype wire
